@@ hdl/ring_fifo_overwrite_indexed_read_assert.svh @@
// Assertion macros for the ring FIFO with overwrite push and indexed read.
`ifndef RING_FIFO_OVERWRITE_INDEXED_READ_ASSERT_SVH
`define RING_FIFO_OVERWRITE_INDEXED_READ_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RFOIR_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define RFOIR_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ hdl/rfoir_pkg.sv @@
// Package: constants, command and status codes, and item structs for the ring FIFO.
package rfoir_pkg;

  localparam int MAX_CAPACITY  = 15;
  localparam int WORD_BITS     = 64;
  localparam int SLOTS         = MAX_CAPACITY + 1;
  localparam int PTR_BITS      = $clog2(SLOTS);
  localparam int CAP_BITS      = 4;
  localparam int IDX_BITS      = 4;
  localparam int CNT_BITS      = 4;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CAP_RESET     = (15 > MAX_CAPACITY) ? MAX_CAPACITY : 15;

  typedef enum logic [1:0] {
    CMD_PUSH       = 2'd0,
    CMD_POP        = 2'd1,
    CMD_OVERWRITE  = 2'd2,
    CMD_READ_INDEX = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  localparam int CFG_REG_CAPACITY = 0;

  typedef struct packed {
    cmd_t                cmd;
    logic [63:0]         write_word;
    logic [IDX_BITS-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [63:0]         read_word;
    status_t             status;
    logic                is_full;
    logic                is_empty;
    logic [CNT_BITS-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic                 wr_en;
    logic [PTR_BITS-1:0]  wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [PTR_BITS-1:0]  rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic                use_mem;
    status_t             status;
    logic                is_full;
    logic                is_empty;
    logic [CNT_BITS-1:0] entry_count;
  } rsp_info_t;

  function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] p,
                                                  input logic [PTR_BITS-1:0] cap);
    advance = (p >= cap) ? '0 : p + PTR_BITS'(1);
  endfunction

endpackage

@@ hdl/rfoir_store.sv @@
// Ring storage: synchronous memory with per-entry valid bits and a registered read.
module rfoir_store (
  input  logic                          clk,
  input  logic                          rst,
  input  rfoir_pkg::mem_req_t           mreq,
  output logic [rfoir_pkg::WORD_BITS-1:0] rd_data
);

  logic [rfoir_pkg::WORD_BITS-1:0] mem [rfoir_pkg::SLOTS];
  logic [rfoir_pkg::SLOTS-1:0]     valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (mreq.wr_en) begin
      valid[mreq.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (mreq.rd_en) begin
      rd_data <= valid[mreq.rd_addr] ? mem[mreq.rd_addr] : '0;
    end
  end

endmodule

@@ hdl/rfoir_ctrl.sv @@
// Pointer control: command decode, pointer and count update, memory requests.
module rfoir_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               go,
  input  rfoir_pkg::req_t                    req,
  input  logic [rfoir_pkg::PTR_BITS-1:0]     capacity,
  input  logic                               clear,
  output rfoir_pkg::mem_req_t                mreq,
  output rfoir_pkg::rsp_info_t               info
);

  localparam int SUM_BITS = rfoir_pkg::PTR_BITS + 1;

  logic [rfoir_pkg::PTR_BITS-1:0] wp, wp_next;
  logic [rfoir_pkg::PTR_BITS-1:0] rp, rp_next;
  logic [rfoir_pkg::CNT_BITS-1:0] count, count_next;

  logic                           full0, empty0;
  logic [rfoir_pkg::PTR_BITS-1:0] rp1;
  logic [rfoir_pkg::CNT_BITS-1:0] count1;
  logic [SUM_BITS-1:0]            pos;
  logic [SUM_BITS-1:0]            cap_ext;

  always_comb begin
    full0   = (rfoir_pkg::advance(wp, capacity) == rp);
    empty0  = (wp == rp);
    cap_ext = SUM_BITS'(capacity);
    pos     = SUM_BITS'(req.read_index) + SUM_BITS'(rp);
    if (pos > cap_ext) begin
      pos = pos - (cap_ext + SUM_BITS'(1));
    end
    rp1    = rp;
    count1 = count;
    if (full0 && !empty0) begin
      rp1    = rfoir_pkg::advance(rp, capacity);
      count1 = count - rfoir_pkg::CNT_BITS'(1);
    end

    wp_next      = wp;
    rp_next      = rp;
    count_next   = count;
    mreq.wr_en   = 1'b0;
    mreq.wr_addr = wp;
    mreq.wr_data = req.write_word[rfoir_pkg::WORD_BITS-1:0];
    mreq.rd_en   = 1'b0;
    mreq.rd_addr = rp;
    info.use_mem = 1'b0;
    info.status  = rfoir_pkg::ST_OK;

    unique case (req.cmd)
      rfoir_pkg::CMD_PUSH: begin
        if (full0) begin
          info.status = rfoir_pkg::ST_DROPPED;
        end else begin
          mreq.wr_en = go;
          wp_next    = rfoir_pkg::advance(wp, capacity);
          count_next = count + rfoir_pkg::CNT_BITS'(1);
        end
      end
      rfoir_pkg::CMD_POP: begin
        if (empty0) begin
          info.status = rfoir_pkg::ST_EMPTY;
        end else begin
          mreq.rd_en   = go;
          info.use_mem = 1'b1;
          rp_next      = rfoir_pkg::advance(rp, capacity);
          count_next   = count - rfoir_pkg::CNT_BITS'(1);
        end
      end
      rfoir_pkg::CMD_OVERWRITE: begin
        rp_next    = rp1;
        count_next = count1;
        if (rfoir_pkg::advance(wp, capacity) == rp1) begin
          info.status = rfoir_pkg::ST_DROPPED;
        end else begin
          mreq.wr_en = go;
          wp_next    = rfoir_pkg::advance(wp, capacity);
          count_next = count1 + rfoir_pkg::CNT_BITS'(1);
        end
      end
      rfoir_pkg::CMD_READ_INDEX: begin
        if (SUM_BITS'(req.read_index) >= cap_ext) begin
          info.status = rfoir_pkg::ST_RANGE;
        end else begin
          mreq.rd_en   = go;
          mreq.rd_addr = pos[rfoir_pkg::PTR_BITS-1:0];
          info.use_mem = 1'b1;
        end
      end
    endcase

    info.is_full     = (rfoir_pkg::advance(wp_next, capacity) == rp_next);
    info.is_empty    = (wp_next == rp_next);
    info.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else if (go) begin
      wp    <= wp_next;
      rp    <= rp_next;
      count <= count_next;
    end
  end

endmodule

@@ hdl/ring_fifo_overwrite_indexed_read.sv @@
// Ring-buffer FIFO with overwrite push and indexed read: top level.
//
// Request channel (req_valid, req_stall, req) carries one command per item:
// push, pop, overwrite push, or read at index. Response channel (rsp_valid,
// rsp_stall, rsp) returns exactly one item per command, in order, with the
// read word, a status code, full and empty flags and the entry count.
// An accepted request passes through a middle stage and then the response
// register, from which the receiver takes it when rsp_stall is low.
// One request is taken every cycle while the response side keeps up. The
// rate is set by the pointer and count update, done in the cycle a request
// is accepted; the registered read of the ring memory adds a middle stage that
// holds its item until the response register frees up.
// When the receiver stalls, the response register holds its item, the middle
// stage holds the next one, and req_stall rises once both are occupied.
// Reset empties the queue, sets capacity to 15 and makes every slot read as
// zero until written. A write to the capacity register over the APB port
// also empties the queue but keeps the slot contents; write it only while
// no items are in flight.
module ring_fifo_overwrite_indexed_read (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  rfoir_pkg::req_t                        req,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output rfoir_pkg::rsp_t                        rsp,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [rfoir_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [rfoir_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [rfoir_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                   pready
);

  `include "ring_fifo_overwrite_indexed_read_assert.svh"

  localparam int REG_SEL_LSB = 2;

  logic [rfoir_pkg::PTR_BITS-1:0]  capacity;
  logic [rfoir_pkg::CAP_BITS-1:0]  cap_wdata;
  logic                            cfg_sel;
  logic                            cfg_write;

  logic                            go;
  logic                            s1_valid;
  logic                            s1_move;
  rfoir_pkg::rsp_info_t            s1_info;
  rfoir_pkg::rsp_info_t            info;
  rfoir_pkg::mem_req_t             mreq;
  logic [rfoir_pkg::WORD_BITS-1:0] rd_data;

  assign pready    = 1'b1;
  assign cfg_sel   = (int'(paddr[rfoir_pkg::CFG_ADDR_BITS-1:REG_SEL_LSB])
                      == rfoir_pkg::CFG_REG_CAPACITY);
  assign cfg_write = psel && penable && pwrite && pready && cfg_sel;
  assign cap_wdata = pwdata[rfoir_pkg::CAP_BITS-1:0];
  assign prdata    = cfg_sel ? rfoir_pkg::CFG_DATA_BITS'(capacity) : '0;

  // saturate to MAX_CAPACITY
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= rfoir_pkg::PTR_BITS'(rfoir_pkg::CAP_RESET);
    end else if (cfg_write) begin
      capacity <= (int'(cap_wdata) > rfoir_pkg::MAX_CAPACITY)
                  ? rfoir_pkg::PTR_BITS'(rfoir_pkg::MAX_CAPACITY)
                  : rfoir_pkg::PTR_BITS'(cap_wdata);
    end
  end

  assign s1_move   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !s1_move;
  assign go        = req_valid && !req_stall;

  rfoir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .req      (req),
    .capacity (capacity),
    .clear    (cfg_write),
    .mreq     (mreq),
    .info     (info)
  );

  rfoir_store u_store (
    .clk     (clk),
    .rst     (rst),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (go) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s1_info <= info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.read_word   <= s1_info.use_mem ? 64'(rd_data) : '0;
      rsp.status      <= s1_info.status;
      rsp.is_full     <= s1_info.is_full;
      rsp.is_empty    <= s1_info.is_empty;
      rsp.entry_count <= s1_info.entry_count;
    end
  end

  `RFOIR_ASSERT_NEXT(a_accept_fills_stage, go, s1_valid, "accepted item lost before middle stage")
  `RFOIR_ASSERT_NOW(a_error_zero_word, rsp_valid && (rsp.status != rfoir_pkg::ST_OK), rsp.read_word == '0, "error response carries a nonzero word")
  `RFOIR_ASSERT_NOW(a_empty_zero_count, rsp_valid && rsp.is_empty, rsp.entry_count == '0, "empty queue reports nonzero count")
  `RFOIR_ASSERT_NOW(a_no_overrun, s1_valid && rsp_valid && rsp_stall, req_stall, "request taken with no room for its response")

endmodule

@@ dv/ring_fifo_overwrite_indexed_read_checker.sv @@
// Checker for the ring FIFO: predicts every response and compares it with the block's output.
module ring_fifo_overwrite_indexed_read_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  input  logic                                req_stall,
  input  rfoir_pkg::req_t                     req,
  input  logic                                rsp_valid,
  input  logic                                rsp_stall,
  input  rfoir_pkg::rsp_t                     rsp,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rfoir_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [rfoir_pkg::CFG_DATA_BITS-1:0] pwdata,
  input  logic [rfoir_pkg::CFG_DATA_BITS-1:0] prdata,
  input  logic                                pready,
  output int                                  pending,
  output int                                  errors,
  output int                                  checked
);

  logic [rfoir_pkg::WORD_BITS-1:0] slot_word [rfoir_pkg::SLOTS];
  int unsigned                     head_slot;
  int unsigned                     tail_slot;
  int unsigned                     fill_level;
  int unsigned                     cap_now;
  rfoir_pkg::rsp_t                 awaited_rsp [$];
  int                              err_count = 0;
  int                              match_count = 0;
  logic                            cap_sel;

  assign cap_sel = (int'(paddr[rfoir_pkg::CFG_ADDR_BITS-1:2]) == rfoir_pkg::CFG_REG_CAPACITY);

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  function automatic int unsigned next_slot(int unsigned p);
    return (p + 1 > cap_now) ? 0 : p + 1;
  endfunction

  function automatic bit ring_full();
    return next_slot(tail_slot) == head_slot;
  endfunction

  function automatic bit ring_empty();
    return tail_slot == head_slot;
  endfunction

  function automatic bit store_word(logic [63:0] w);
    if (ring_full()) begin
      return 1'b0;
    end
    slot_word[tail_slot % rfoir_pkg::SLOTS] = w;
    tail_slot = next_slot(tail_slot);
    fill_level = fill_level + 1;
    return 1'b1;
  endfunction

  function automatic logic [63:0] take_oldest();
    logic [63:0] w;
    if (ring_empty()) begin
      return '0;
    end
    w = slot_word[head_slot % rfoir_pkg::SLOTS];
    head_slot = next_slot(head_slot);
    fill_level = fill_level - 1;
    return w;
  endfunction

  function automatic rfoir_pkg::rsp_t apply_command(rfoir_pkg::req_t r);
    rfoir_pkg::rsp_t o;
    int unsigned     pos;
    o = '0;
    o.status = rfoir_pkg::ST_OK;
    case (r.cmd)
      rfoir_pkg::CMD_PUSH: begin
        if (!store_word(r.write_word)) o.status = rfoir_pkg::ST_DROPPED;
      end
      rfoir_pkg::CMD_POP: begin
        if (ring_empty()) o.status = rfoir_pkg::ST_EMPTY;
        else o.read_word = take_oldest();
      end
      rfoir_pkg::CMD_OVERWRITE: begin
        if (ring_full()) void'(take_oldest());
        if (!store_word(r.write_word)) o.status = rfoir_pkg::ST_DROPPED;
      end
      default: begin
        if (r.read_index >= cap_now) begin
          o.status = rfoir_pkg::ST_RANGE;
        end else begin
          pos = r.read_index + head_slot;
          if (pos > cap_now) pos = pos - (cap_now + 1);
          o.read_word = slot_word[pos % rfoir_pkg::SLOTS];
        end
      end
    endcase
    o.is_full = ring_full();
    o.is_empty = ring_empty();
    o.entry_count = rfoir_pkg::CNT_BITS'(fill_level);
    return o;
  endfunction

  always @(posedge clk) begin : watch
    rfoir_pkg::rsp_t want;
    if (rst) begin
      for (int i = 0; i < rfoir_pkg::SLOTS; i++) slot_word[i] = '0;
      head_slot = 0;
      tail_slot = 0;
      fill_level = 0;
      cap_now = rfoir_pkg::CAP_RESET;
      awaited_rsp.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (cap_sel) begin
            cap_now = (int'(pwdata[3:0]) > rfoir_pkg::MAX_CAPACITY)
                      ? rfoir_pkg::MAX_CAPACITY : int'(pwdata[3:0]);
            head_slot = 0;
            tail_slot = 0;
            fill_level = 0;
          end
        end else if (cap_sel && prdata !== rfoir_pkg::CFG_DATA_BITS'(cap_now)) begin
          report_mismatch("capacity readback", 64'(prdata), 64'(cap_now));
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("response with nothing outstanding", rsp.read_word, '0);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.read_word !== want.read_word)
            report_mismatch("read_word", rsp.read_word, want.read_word);
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.is_full !== want.is_full)
            report_mismatch("is_full", 64'(rsp.is_full), 64'(want.is_full));
          if (rsp.is_empty !== want.is_empty)
            report_mismatch("is_empty", 64'(rsp.is_empty), 64'(want.is_empty));
          if (rsp.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(rsp.entry_count), 64'(want.entry_count));
          match_count++;
        end
      end
      if (req_valid && !req_stall) begin
        awaited_rsp.push_back(apply_command(req));
      end
    end
    pending <= awaited_rsp.size();
    errors <= err_count;
    checked <= match_count;
  end

endmodule

@@ dv/ring_fifo_overwrite_indexed_read_tb.sv @@
// Testbench top for the ring FIFO: clock, reset, command and register stimulus, and verdict.
module ring_fifo_overwrite_indexed_read_tb;

  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 95;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                req_valid = 1'b0;
  logic                                req_stall;
  rfoir_pkg::req_t                     req = '0;
  logic                                rsp_valid;
  logic                                rsp_stall = 1'b0;
  rfoir_pkg::rsp_t                     rsp;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [rfoir_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
  logic [rfoir_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
  logic [rfoir_pkg::CFG_DATA_BITS-1:0] prdata;
  logic                                pready;

  int pending;
  int errors;
  int checked;
  bit idle_on = 1'b1;
  int quiet_cycles = 0;
  int items_sent = 0;
  int cap_writes = 0;
  int phase_caps [10] = '{15, 2, 8, 1, 15, 4, 7, 11, 3, 15};

  always #5 clk = ~clk;

  ring_fifo_overwrite_indexed_read DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ring_fifo_overwrite_indexed_read_checker checker_i (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pending(pending), .errors(errors), .checked(checked)
  );

  always @(posedge clk) begin
    rsp_stall <= idle_on && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_cmd(rfoir_pkg::cmd_t c, logic [63:0] w,
                          logic [rfoir_pkg::IDX_BITS-1:0] idx);
    rfoir_pkg::req_t item;
    item.cmd = c;
    item.write_word = w;
    item.read_index = idx;
    if (idle_on && $urandom_range(99) < 18) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_access(bit wr, logic [rfoir_pkg::CFG_ADDR_BITS-1:0] a,
                            logic [rfoir_pkg::CFG_DATA_BITS-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_capacity(int cap);
    cfg_access(1'b1, rfoir_pkg::CFG_ADDR_BITS'(4 * rfoir_pkg::CFG_REG_CAPACITY),
               {28'($urandom), 4'(cap)});
    cfg_access(1'b0, rfoir_pkg::CFG_ADDR_BITS'(4 * rfoir_pkg::CFG_REG_CAPACITY), '0);
    cap_writes++;
  endtask

  initial begin
    int                             pick;
    int                             cap;
    rfoir_pkg::cmd_t                c;
    logic [63:0]                    w;
    logic [rfoir_pkg::IDX_BITS-1:0] idx;
    bit                             fill;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full capacity out of reset: reads of cleared slots, range edge, empty pop
    send_cmd(rfoir_pkg::CMD_READ_INDEX, '0, 4'd0);
    send_cmd(rfoir_pkg::CMD_READ_INDEX, '1, 4'd14);
    send_cmd(rfoir_pkg::CMD_READ_INDEX, '0, 4'd15);
    send_cmd(rfoir_pkg::CMD_POP, '1, 4'd15);
    send_cmd(rfoir_pkg::CMD_PUSH, '1, 4'd0);
    send_cmd(rfoir_pkg::CMD_PUSH, '0, 4'd0);
    send_cmd(rfoir_pkg::CMD_PUSH, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0);
    send_cmd(rfoir_pkg::CMD_OVERWRITE, 64'h5A5A_5A5A_5A5A_5A5A, 4'd0);
    send_cmd(rfoir_pkg::CMD_READ_INDEX, '0, 4'd1);
    send_cmd(rfoir_pkg::CMD_READ_INDEX, '0, 4'd5);
    send_cmd(rfoir_pkg::CMD_POP, '0, 4'd0);
    send_cmd(rfoir_pkg::CMD_POP, '0, 4'd0);
    wait_idle();

    // single entry: drop on full, overwrite discards oldest
    set_capacity(1);
    send_cmd(rfoir_pkg::CMD_PUSH, 64'h0123_4567_89AB_CDEF, 4'd0);
    send_cmd(rfoir_pkg::CMD_PUSH, 64'hFEDC_BA98_7654_3210, 4'd0);
    send_cmd(rfoir_pkg::CMD_OVERWRITE, 64'h8000_0000_0000_0001, 4'd0);
    send_cmd(rfoir_pkg::CMD_READ_INDEX, '0, 4'd0);
    send_cmd(rfoir_pkg::CMD_READ_INDEX, '0, 4'd1);
    send_cmd(rfoir_pkg::CMD_POP, '0, 4'd0);
    send_cmd(rfoir_pkg::CMD_POP, '0, 4'd0);
    wait_idle();

    // write outside the register map must be ignored
    cfg_access(1'b1, rfoir_pkg::CFG_ADDR_BITS'(4), 32'd5);
    cfg_access(1'b0, rfoir_pkg::CFG_ADDR_BITS'(4 * rfoir_pkg::CFG_REG_CAPACITY), '0);

    // zero capacity: always empty and full at once
    set_capacity(0);
    send_cmd(rfoir_pkg::CMD_PUSH, '1, 4'd0);
    send_cmd(rfoir_pkg::CMD_OVERWRITE, '1, 4'd0);
    send_cmd(rfoir_pkg::CMD_POP, '0, 4'd0);
    send_cmd(rfoir_pkg::CMD_READ_INDEX, '0, 4'd0);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      cap = phase_caps[p];
      idle_on <= (p != 4 && p != 5);
      set_capacity(cap);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 60 && p % 2 == 1) wait_idle();
        fill = ((n / 40) % 2 == 0);
        pick = $urandom_range(99);
        if (fill) begin
          c = (pick < 35) ? rfoir_pkg::CMD_PUSH : (pick < 60) ? rfoir_pkg::CMD_OVERWRITE :
              (pick < 72) ? rfoir_pkg::CMD_POP : rfoir_pkg::CMD_READ_INDEX;
        end else begin
          c = (pick < 15) ? rfoir_pkg::CMD_PUSH : (pick < 25) ? rfoir_pkg::CMD_OVERWRITE :
              (pick < 65) ? rfoir_pkg::CMD_POP : rfoir_pkg::CMD_READ_INDEX;
        end
        pick = $urandom_range(7);
        w = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
        if ($urandom_range(1) == 0 || cap == 0) begin
          idx = rfoir_pkg::IDX_BITS'($urandom_range(15));
        end else begin
          idx = rfoir_pkg::IDX_BITS'($urandom_range(cap - 1));
        end
        send_cmd(c, w, idx);
      end
      wait_idle();
    end

    $display("sent %0d commands under %0d capacity settings, checked %0d responses",
             items_sent, cap_writes, checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/rfoir_pkg.sv
hdl/rfoir_store.sv
hdl/rfoir_ctrl.sv
hdl/ring_fifo_overwrite_indexed_read.sv
dv/ring_fifo_overwrite_indexed_read_checker.sv
dv/ring_fifo_overwrite_indexed_read_tb.sv
